// ===== design/igrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igrd_pkg
// Shared types and constants of the IMU gesture run detector.
// ----------------------------------------------------------------------------
package igrd_pkg;

  // Command carried with each item; code 3 is unused and treated as a no-op.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } op_e;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TOTAL_W  = 7;
  localparam int unsigned MIN_RUN_W = 16;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_X_UPPER      = 3'd0;
  localparam logic [2:0] REG_SIP_X_LOWER  = 3'd1;
  localparam logic [2:0] REG_EAT_X_LOWER  = 3'd2;
  localparam logic [2:0] REG_EAT_Z_UPPER  = 3'd3;
  localparam logic [2:0] REG_EAT_Z_LOWER  = 3'd4;
  localparam logic [2:0] REG_EAT_GYRO_MIN = 3'd5;
  localparam logic [2:0] REG_SIP_MIN_RUN  = 3'd6;
  localparam logic [2:0] REG_EAT_MIN_RUN  = 3'd7;

  // Reset bit patterns, 16 bits; zero-extended or truncated to sample width
  localparam logic [15:0] RST_X_UPPER      = 16'hFE00;  // -4 m/s2
  localparam logic [15:0] RST_SIP_X_LOWER  = 16'hFC00;  // -8 m/s2
  localparam logic [15:0] RST_EAT_X_LOWER  = 16'hFB80;  // -9 m/s2
  localparam logic [15:0] RST_EAT_Z_UPPER  = 16'h0380;  //  7 m/s2
  localparam logic [15:0] RST_EAT_Z_LOWER  = 16'h0100;  //  2 m/s2
  localparam logic [15:0] RST_EAT_GYRO_MIN = 16'h0960;  // 150 deg/s
  localparam logic [15:0] RST_SIP_MIN_RUN  = 16'd40;
  localparam logic [15:0] RST_EAT_MIN_RUN  = 16'd5;

  localparam logic [TOTAL_W-1:0] TOTAL_LAST = 7'd99;

  typedef struct packed {
    logic sip;
    logic eat;
  } qual_t;

  function automatic logic [TOTAL_W-1:0] total_next(input logic [TOTAL_W-1:0] c);
    total_next = (c >= TOTAL_LAST) ? '0 : c + 1'b1;
  endfunction

endpackage

// ===== design/igrd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igrd_if
// Valid/ready channels for sample items and result items.
// ----------------------------------------------------------------------------
interface igrd_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic signed [SAMPLE_BITS-1:0] acc_x;
  logic signed [SAMPLE_BITS-1:0] acc_y;
  logic signed [SAMPLE_BITS-1:0] acc_z;
  logic signed [SAMPLE_BITS-1:0] gyro_z;

  modport source (output valid, op, acc_x, acc_y, acc_z, gyro_z, input ready);
  modport sink   (input valid, op, acc_x, acc_y, acc_z, gyro_z, output ready);
endinterface

interface igrd_out_if;
  logic       valid;
  logic       ready;
  logic       sip_event;
  logic       eat_event;
  logic [6:0] sip_total;
  logic [6:0] eat_total;

  modport source (output valid, sip_event, eat_event, sip_total, eat_total, input ready);
  modport sink   (input valid, sip_event, eat_event, sip_total, eat_total, output ready);
endinterface

// ===== design/igrd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igrd_cfg_regs
// APB register file holding the detector windows and minimum run lengths.
// ----------------------------------------------------------------------------
module igrd_cfg_regs #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [igrd_pkg::ADDR_W-1:0]       paddr,
  input  logic [igrd_pkg::DATA_W-1:0]       pwdata,
  output logic [igrd_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output logic signed [SAMPLE_BITS-1:0]     x_upper_o,
  output logic signed [SAMPLE_BITS-1:0]     sip_x_lower_o,
  output logic signed [SAMPLE_BITS-1:0]     eat_x_lower_o,
  output logic signed [SAMPLE_BITS-1:0]     eat_z_upper_o,
  output logic signed [SAMPLE_BITS-1:0]     eat_z_lower_o,
  output logic signed [SAMPLE_BITS-1:0]     eat_gyro_min_o,
  output logic [igrd_pkg::MIN_RUN_W-1:0]    sip_min_run_o,
  output logic [igrd_pkg::MIN_RUN_W-1:0]    eat_min_run_o
);
  import igrd_pkg::*;

  logic [SAMPLE_BITS-1:0] x_upper_q, sip_x_lower_q, eat_x_lower_q;
  logic [SAMPLE_BITS-1:0] eat_z_upper_q, eat_z_lower_q, eat_gyro_min_q;
  logic [MIN_RUN_W-1:0]   sip_min_run_q, eat_min_run_q;
  logic                   wr_en;
  logic [2:0]             idx;
  logic [SAMPLE_BITS-1:0] wdata_s;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign idx     = paddr[4:2];
  assign wdata_s = pwdata[SAMPLE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_upper_q      <= SAMPLE_BITS'(RST_X_UPPER);
      sip_x_lower_q  <= SAMPLE_BITS'(RST_SIP_X_LOWER);
      eat_x_lower_q  <= SAMPLE_BITS'(RST_EAT_X_LOWER);
      eat_z_upper_q  <= SAMPLE_BITS'(RST_EAT_Z_UPPER);
      eat_z_lower_q  <= SAMPLE_BITS'(RST_EAT_Z_LOWER);
      eat_gyro_min_q <= SAMPLE_BITS'(RST_EAT_GYRO_MIN);
      sip_min_run_q  <= RST_SIP_MIN_RUN;
      eat_min_run_q  <= RST_EAT_MIN_RUN;
    end else if (wr_en) begin
      case (idx)
        REG_X_UPPER:      x_upper_q      <= wdata_s;
        REG_SIP_X_LOWER:  sip_x_lower_q  <= wdata_s;
        REG_EAT_X_LOWER:  eat_x_lower_q  <= wdata_s;
        REG_EAT_Z_UPPER:  eat_z_upper_q  <= wdata_s;
        REG_EAT_Z_LOWER:  eat_z_lower_q  <= wdata_s;
        REG_EAT_GYRO_MIN: eat_gyro_min_q <= wdata_s;
        REG_SIP_MIN_RUN:  sip_min_run_q  <= pwdata[MIN_RUN_W-1:0];
        REG_EAT_MIN_RUN:  eat_min_run_q  <= pwdata[MIN_RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_UPPER:      prdata = DATA_W'(x_upper_q);
      REG_SIP_X_LOWER:  prdata = DATA_W'(sip_x_lower_q);
      REG_EAT_X_LOWER:  prdata = DATA_W'(eat_x_lower_q);
      REG_EAT_Z_UPPER:  prdata = DATA_W'(eat_z_upper_q);
      REG_EAT_Z_LOWER:  prdata = DATA_W'(eat_z_lower_q);
      REG_EAT_GYRO_MIN: prdata = DATA_W'(eat_gyro_min_q);
      REG_SIP_MIN_RUN:  prdata = DATA_W'(sip_min_run_q);
      REG_EAT_MIN_RUN:  prdata = DATA_W'(eat_min_run_q);
      default:          prdata = '0;
    endcase
  end

  assign x_upper_o      = x_upper_q;
  assign sip_x_lower_o  = sip_x_lower_q;
  assign eat_x_lower_o  = eat_x_lower_q;
  assign eat_z_upper_o  = eat_z_upper_q;
  assign eat_z_lower_o  = eat_z_lower_q;
  assign eat_gyro_min_o = eat_gyro_min_q;
  assign sip_min_run_o  = sip_min_run_q;
  assign eat_min_run_o  = eat_min_run_q;

endmodule

// ===== design/igrd_qualify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igrd_qualify
// Window checks deciding whether a sample qualifies for each detector.
// ----------------------------------------------------------------------------
module igrd_qualify #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic signed [SAMPLE_BITS-1:0] acc_x_i,
  input  logic signed [SAMPLE_BITS-1:0] acc_y_i,
  input  logic signed [SAMPLE_BITS-1:0] acc_z_i,
  input  logic signed [SAMPLE_BITS-1:0] gyro_z_i,
  input  logic signed [SAMPLE_BITS-1:0] x_upper_i,
  input  logic signed [SAMPLE_BITS-1:0] sip_x_lower_i,
  input  logic signed [SAMPLE_BITS-1:0] eat_x_lower_i,
  input  logic signed [SAMPLE_BITS-1:0] eat_z_upper_i,
  input  logic signed [SAMPLE_BITS-1:0] eat_z_lower_i,
  input  logic signed [SAMPLE_BITS-1:0] eat_gyro_min_i,
  output igrd_pkg::qual_t               qual_o
);
  import igrd_pkg::*;

  logic x_below;

  // all bounds are exclusive
  assign x_below    = acc_x_i < x_upper_i;
  assign qual_o.sip = x_below && (acc_x_i > sip_x_lower_i) && (acc_y_i > acc_x_i);
  assign qual_o.eat = x_below && (acc_x_i > eat_x_lower_i) &&
                      (acc_z_i < eat_z_upper_i) && (acc_z_i > eat_z_lower_i) &&
                      (gyro_z_i > eat_gyro_min_i);

endmodule

// ===== design/igrd_run_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igrd_run_track
// Run-length counter and modulo-100 event count for one detector.
// ----------------------------------------------------------------------------
module igrd_run_track #(
  parameter int unsigned RUN_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,   // enabled sample processed
  input  logic                             clear_i,  // start or stop processed
  input  logic                             qual_i,
  input  logic [igrd_pkg::MIN_RUN_W-1:0]   min_run_i,
  output logic                             event_o,
  output logic [igrd_pkg::TOTAL_W-1:0]     total_d_o
);
  import igrd_pkg::*;

  localparam int unsigned CMP_W = (RUN_BITS > MIN_RUN_W) ? RUN_BITS : MIN_RUN_W;

  logic [RUN_BITS-1:0] run_q, run_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                long_enough;

  assign long_enough = CMP_W'(run_q) >= CMP_W'(min_run_i);
  assign event_o     = step_i && !qual_i && long_enough;

  always_comb begin
    run_d   = run_q;
    total_d = total_q;
    if (clear_i) begin
      total_d = '0;
    end else if (step_i) begin
      if (qual_i) begin
        // saturate at all ones
        if (run_q != {RUN_BITS{1'b1}}) begin
          run_d = run_q + 1'b1;
        end
      end else begin
        run_d = '0;
        if (long_enough) begin
          total_d = total_next(total_q);
        end
      end
    end
  end

  assign total_d_o = total_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      total_q <= '0;
    end else begin
      run_q   <= run_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== design/imu_gesture_run_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_gesture_run_detector
// Two window detectors counting runs of qualifying IMU samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready items carrying op (sample, start, stop) and the
//            acc_x/acc_y/acc_z/gyro_z fields.
//   out_ch : exactly one result item per input item: sip/eat event flags
//            and the modulo-100 event totals after that item.
//   APB    : eight window/run-length registers at byte address 4*index;
//            write only while no item is in flight.
//   An accepted item passes the input register, then the result register,
//   before result valid. Throughput is one item per cycle while out_ch does
//   not stall; the state update of each item is one compare-and-increment
//   pass between the two registers. When out_ch stalls, the result register
//   holds, the input register fills, and in_ch.ready drops only once both are occupied.
//   Reset disables the block, clears run counters and totals and loads the
//   register defaults; samples are ignored until a start item arrives.
// ----------------------------------------------------------------------------
module imu_gesture_run_detector #(
  parameter int unsigned RUN_BITS    = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  igrd_in_if.sink                     in_ch,
  igrd_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [igrd_pkg::ADDR_W-1:0] paddr,
  input  logic [igrd_pkg::DATA_W-1:0] pwdata,
  output logic [igrd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import igrd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] x_upper, sip_x_lower, eat_x_lower;
  logic signed [SAMPLE_BITS-1:0] eat_z_upper, eat_z_lower, eat_gyro_min;
  logic [MIN_RUN_W-1:0]          sip_min_run, eat_min_run;

  // input register
  logic                          in_valid_q;
  logic [1:0]                    op_q;
  logic signed [SAMPLE_BITS-1:0] acc_x_q, acc_y_q, acc_z_q, gyro_z_q;

  // result register
  logic               out_valid_q;
  logic               sip_event_q, eat_event_q;
  logic [TOTAL_W-1:0] sip_total_q, eat_total_q;

  logic               enabled_q, enabled_d;
  logic               advance, in_take;
  logic               step, clear;
  qual_t              qual;
  logic               sip_ev, eat_ev;
  logic [TOTAL_W-1:0] sip_total_d, eat_total_d;

  igrd_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .x_upper_o      (x_upper),
    .sip_x_lower_o  (sip_x_lower),
    .eat_x_lower_o  (eat_x_lower),
    .eat_z_upper_o  (eat_z_upper),
    .eat_z_lower_o  (eat_z_lower),
    .eat_gyro_min_o (eat_gyro_min),
    .sip_min_run_o  (sip_min_run),
    .eat_min_run_o  (eat_min_run)
  );

  assign advance      = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready  = !in_valid_q || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    step      = 1'b0;
    clear     = 1'b0;
    enabled_d = enabled_q;
    if (advance) begin
      case (op_e'(op_q))
        OP_SAMPLE: step = enabled_q;
        OP_START: begin
          clear     = 1'b1;
          enabled_d = 1'b1;
        end
        OP_STOP: begin
          clear     = 1'b1;
          enabled_d = 1'b0;
        end
        default: ;  // unused code: ignored
      endcase
    end
  end

  igrd_qualify #(.SAMPLE_BITS(SAMPLE_BITS)) u_qualify (
    .acc_x_i        (acc_x_q),
    .acc_y_i        (acc_y_q),
    .acc_z_i        (acc_z_q),
    .gyro_z_i       (gyro_z_q),
    .x_upper_i      (x_upper),
    .sip_x_lower_i  (sip_x_lower),
    .eat_x_lower_i  (eat_x_lower),
    .eat_z_upper_i  (eat_z_upper),
    .eat_z_lower_i  (eat_z_lower),
    .eat_gyro_min_i (eat_gyro_min),
    .qual_o         (qual)
  );

  igrd_run_track #(.RUN_BITS(RUN_BITS)) u_sip (
    .clk_i, .rst_ni,
    .step_i    (step),
    .clear_i   (clear),
    .qual_i    (qual.sip),
    .min_run_i (sip_min_run),
    .event_o   (sip_ev),
    .total_d_o (sip_total_d)
  );

  igrd_run_track #(.RUN_BITS(RUN_BITS)) u_eat (
    .clk_i, .rst_ni,
    .step_i    (step),
    .clear_i   (clear),
    .qual_i    (qual.eat),
    .min_run_i (eat_min_run),
    .event_o   (eat_ev),
    .total_d_o (eat_total_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enabled_q   <= 1'b0;
    end else begin
      enabled_q <= enabled_d;
      if (in_ch.ready) begin
        in_valid_q <= in_ch.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= in_ch.op;
      acc_x_q  <= in_ch.acc_x;
      acc_y_q  <= in_ch.acc_y;
      acc_z_q  <= in_ch.acc_z;
      gyro_z_q <= in_ch.gyro_z;
    end
    if (advance) begin
      sip_event_q <= sip_ev;
      eat_event_q <= eat_ev;
      sip_total_q <= sip_total_d;
      eat_total_q <= eat_total_d;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.sip_event = sip_event_q;
  assign out_ch.eat_event = eat_event_q;
  assign out_ch.sip_total = sip_total_q;
  assign out_ch.eat_total = eat_total_q;

endmodule
